[rtl/core/cdt_pkg.sv]
// ----------------------------------------------------------------------------
// Countdown timer package
// Shared types, constants and segment helpers for the countdown timer.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int unsigned REM_W      = 19;
    localparam int unsigned LED_W      = 10;
    localparam int unsigned BLINK_W    = 3;
    localparam int unsigned BLINK_TIMES = 3;

    localparam logic [LED_W-1:0] LEDS_ALL      = 10'h3FF;
    localparam logic [REM_W-1:0] INIT_RESET    = 19'd3615;
    localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]       SECS_PER_MIN  = 6'd60;

    // floor(2^20 / 3600) and floor(2^12 / 60); quotient may come out one low
    localparam logic [8:0]  HOUR_RECIP       = 9'd291;
    localparam int unsigned HOUR_RECIP_SHIFT = 20;
    localparam logic [6:0]  MIN_RECIP        = 7'd68;
    localparam int unsigned MIN_RECIP_SHIFT  = 12;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef logic [3:0] clear_t;
    localparam clear_t CLEAR_NONE   = 4'd0;
    localparam clear_t CLEAR_RELOAD = 4'd1;
    localparam clear_t CLEAR_OTHER  = 4'd6;
    localparam clear_t CLEAR_RUN    = 4'd8;

    // status that rides alongside the digit arithmetic
    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic             running;
        clear_t           button_clear;
        logic [REM_W-1:0] elapsed;
    } side_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'hcf;
            4'd4:    s = 8'he6;
            4'd5:    s = 8'hed;
            4'd6:    s = 8'hfd;
            4'd7:    s = 8'h87;
            4'd8:    s = 8'hff;
            4'd9:    s = 8'hef;
            default: s = 8'h3f;
        endcase
        return s;
    endfunction

    // two segment bytes (tens, units) of a value below 100
    function automatic logic [15:0] seg_pair(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] units;
        tens = 4'd0;
        for (int i = 1; i < 10; i++)
        begin
            if (v >= 7'(i * 10))
            begin
                tens = 4'(i);
            end
        end
        units = v - 7'(tens) * 7'd10;
        return {seg_code(tens), seg_code(units[3:0])};
    endfunction

endpackage

[rtl/core/cdt_cmd_if.sv]
// ----------------------------------------------------------------------------
// Countdown timer command channel
// Valid/ready channel carrying one timer event item.
// ----------------------------------------------------------------------------
interface cdt_cmd_if
    import cdt_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] buttons;

    modport source (output valid, output kind, output buttons, input ready);
    modport sink   (input valid, input kind, input buttons, output ready);
endinterface

[rtl/core/cdt_result_if.sv]
// ----------------------------------------------------------------------------
// Countdown timer result channel
// Valid/ready channel carrying one display/status item.
// ----------------------------------------------------------------------------
interface cdt_result_if
    import cdt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [31:0]      seg_minutes_seconds;
    logic [15:0]      seg_hours;
    logic [LED_W-1:0] leds;
    logic [REM_W-1:0] elapsed_seconds;
    logic             running;
    logic [3:0]       button_clear;

    modport source (
        output valid, output seg_minutes_seconds, output seg_hours, output leds,
        output elapsed_seconds, output running, output button_clear, input ready
    );
    modport sink (
        input valid, input seg_minutes_seconds, input seg_hours, input leds,
        input elapsed_seconds, input running, input button_clear, output ready
    );
endinterface

[rtl/core/countdown_timer_seven_segment.sv]
// ----------------------------------------------------------------------------
// Countdown timer with seven-segment display
// Seconds countdown, LED blink at zero, button control, hh:mm:ss segments.
// ----------------------------------------------------------------------------
// Path: an accepted item passes stages 1 to 5, then the output register.
// Throughput: one item per cycle; the six-stage pipe stalls as a whole
// while the output register holds an untaken result.
// Reset: count 3615 s, running, LEDs off, blink count 0, pipe empty.
// ----------------------------------------------------------------------------
module countdown_timer_seven_segment
    import cdt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  logic [REM_W-1:0] cfg_wdata,
    cdt_cmd_if.sink          cmd,
    cdt_result_if.source     result
);

    // ------------------------------------------------------------------
    // Timer state and start-value register
    // ------------------------------------------------------------------
    logic [REM_W-1:0]   init_reg;
    logic [REM_W-1:0]   remaining_reg, remaining_next;
    logic               run_flag_reg, run_flag_next;
    logic [BLINK_W-1:0] blink_count_reg, blink_count_next;
    logic [LED_W-1:0]   led_pattern_reg, led_pattern_next;
    clear_t             clear_next;
    logic [BLINK_W-1:0] blink_inc;

    // global pipe advance: everything moves unless the output is stuck
    logic advance;
    logic accept;

    assign advance   = !(result.valid && !result.ready);
    assign cmd.ready = advance;
    assign accept    = cmd.valid && cmd.ready;
    assign blink_inc = blink_count_reg + BLINK_W'(1);

    // event decode; the new state is also the snapshot sent down the pipe
    always_comb
    begin
        remaining_next   = remaining_reg;
        run_flag_next    = run_flag_reg;
        blink_count_next = blink_count_reg;
        led_pattern_next = led_pattern_reg;
        clear_next       = CLEAR_NONE;
        case (kind_t'(cmd.kind))
            KIND_TICK:
            begin
                if (run_flag_reg)
                begin
                    if (remaining_reg == '0)
                    begin
                        // at zero a tick blinks; reload after the last blink
                        led_pattern_next = ~led_pattern_reg & LEDS_ALL;
                        if (blink_inc >= BLINK_W'(2 * BLINK_TIMES))
                        begin
                            blink_count_next = '0;
                            remaining_next   = init_reg;
                        end
                        else
                        begin
                            blink_count_next = blink_inc;
                        end
                    end
                    else
                    begin
                        remaining_next = remaining_reg - REM_W'(1);
                    end
                end
            end
            KIND_BUTTON:
            begin
                if (cmd.buttons[3])
                begin
                    run_flag_next = !run_flag_reg;
                    clear_next    = CLEAR_RUN;
                end
                else if (cmd.buttons == 4'd1)
                begin
                    remaining_next = init_reg;
                    clear_next     = CLEAR_RELOAD;
                end
                else
                begin
                    clear_next = CLEAR_OTHER;
                end
            end
            default:
            begin
                // status query: no change
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg        <= INIT_RESET;
            remaining_reg   <= INIT_RESET;
            run_flag_reg    <= 1'b1;
            blink_count_reg <= '0;
            led_pattern_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                init_reg <= cfg_wdata;
            end
            if (accept)
            begin
                remaining_reg   <= remaining_next;
                run_flag_reg    <= run_flag_next;
                blink_count_reg <= blink_count_next;
                led_pattern_reg <= led_pattern_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipe valid bits (stages 1..5, then output register)
    // ------------------------------------------------------------------
    logic [5:1] vld_reg;
    logic       out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[4:1], accept};
            out_vld_reg <= vld_reg[5];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: state snapshot
    // ------------------------------------------------------------------
    logic [REM_W-1:0] rem1_reg;
    side_t            side1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem1_reg               <= remaining_next;
            side1_reg.leds         <= led_pattern_next;
            side1_reg.running      <= run_flag_next;
            side1_reg.button_clear <= clear_next;
            side1_reg.elapsed      <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: hour estimate by reciprocal, elapsed time
    // ------------------------------------------------------------------
    logic [27:0]      hprod;
    logic [REM_W-1:0] rem2_reg;
    logic [7:0]       hq2_reg;
    side_t            side2_reg;

    // the user must write config only while idle so init_reg is steady here; the block does not enforce it
    assign hprod = 28'(rem1_reg) * 28'(HOUR_RECIP);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem2_reg               <= rem1_reg;
            hq2_reg                <= hprod[HOUR_RECIP_SHIFT +: 8];
            side2_reg.leds         <= side1_reg.leds;
            side2_reg.running      <= side1_reg.running;
            side2_reg.button_clear <= side1_reg.button_clear;
            side2_reg.elapsed      <= (init_reg >= rem1_reg) ? (init_reg - rem1_reg) : '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: hour correction, seconds within the hour
    // ------------------------------------------------------------------
    logic [19:0] hrem;
    logic [7:0]  hours3_reg;
    logic [11:0] hrest3_reg;
    side_t       side3_reg;

    assign hrem = 20'(rem2_reg) - 20'(hq2_reg) * 20'(SECS_PER_HOUR);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side3_reg <= side2_reg;
            if (hrem >= 20'(SECS_PER_HOUR))
            begin
                hours3_reg <= hq2_reg + 8'd1;
                hrest3_reg <= 12'(hrem - 20'(SECS_PER_HOUR));
            end
            else
            begin
                hours3_reg <= hq2_reg;
                hrest3_reg <= 12'(hrem);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: minute estimate by reciprocal
    // ------------------------------------------------------------------
    logic [18:0] mprod;
    logic [7:0]  hours4_reg;
    logic [11:0] hrest4_reg;
    logic [5:0]  mq4_reg;
    side_t       side4_reg;

    assign mprod = 19'(hrest3_reg) * 19'(MIN_RECIP);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hours4_reg <= hours3_reg;
            hrest4_reg <= hrest3_reg;
            mq4_reg    <= mprod[MIN_RECIP_SHIFT +: 6];
            side4_reg  <= side3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: minute correction, seconds; hours folded below 100
    // ------------------------------------------------------------------
    logic [11:0] srem;
    logic [6:0]  hours5_reg;
    logic [5:0]  mins5_reg;
    logic [5:0]  secs5_reg;
    side_t       side5_reg;

    assign srem = hrest4_reg - 12'(mq4_reg) * 12'(SECS_PER_MIN);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side5_reg  <= side4_reg;
            // at most 145 hours fit in 19 bits: one subtract is enough
            hours5_reg <= (hours4_reg >= 8'd100) ? 7'(hours4_reg - 8'd100)
                                                 : 7'(hours4_reg);
            if (srem >= 12'(SECS_PER_MIN))
            begin
                mins5_reg <= mq4_reg + 6'd1;
                secs5_reg <= 6'(srem - 12'(SECS_PER_MIN));
            end
            else
            begin
                mins5_reg <= mq4_reg;
                secs5_reg <= 6'(srem);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: segment lookup
    // ------------------------------------------------------------------
    logic [31:0] seg_ms_reg;
    logic [15:0] seg_h_reg;
    side_t       side_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            seg_ms_reg   <= {seg_pair(7'(mins5_reg)), seg_pair(7'(secs5_reg))};
            seg_h_reg    <= seg_pair(hours5_reg);
            side_out_reg <= side5_reg;
        end
    end

    assign result.valid               = out_vld_reg;
    assign result.seg_minutes_seconds = seg_ms_reg;
    assign result.seg_hours           = seg_h_reg;
    assign result.leds                = side_out_reg.leds;
    assign result.elapsed_seconds     = side_out_reg.elapsed;
    assign result.running             = side_out_reg.running;
    assign result.button_clear        = side_out_reg.button_clear;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_blink_bound: assert property (@(posedge clk) disable iff (!rst_n)
        blink_count_reg < BLINK_W'(2 * BLINK_TIMES))
        else $error("blink count past its limit");

    a_tick_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.kind == KIND_TICK) && run_flag_reg && (remaining_reg != '0)
        |=> remaining_reg == $past(remaining_reg) - REM_W'(1))
        else $error("running tick did not decrement the count");

    a_leds_whole: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.leds == '0) || (result.leds == LEDS_ALL))
        else $error("LED pattern neither all on nor all off");

    a_clear_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.button_clear == CLEAR_NONE)
                      || (result.button_clear == CLEAR_RELOAD)
                      || (result.button_clear == CLEAR_OTHER)
                      || (result.button_clear == CLEAR_RUN))
        else $error("illegal button clear code");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Countdown timer with seven-segment display: testbench
// Sends tick, button and query items with random gaps and back-pressure. It
// models the count, the blink and the run state in the bench, and checks
// every display/status item field by field, in order, against that model.
// ----------------------------------------------------------------------------
module testbench;
    import cdt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned ITEM_TARGET  = 550;
    localparam int unsigned DRAIN_CYCLES = 20;     // pipe is six deep
    localparam int unsigned PRINT_LIMIT  = 60;

    localparam logic [1:0]       KIND_SPARE  = 2'd3;     // undecoded kind, behaves as a query
    localparam logic [3:0]       KEY_RELOAD  = 4'd1;     // key0 alone reloads the count
    localparam logic [3:0]       KEY_RUN     = 4'd8;     // key3 (and up) toggles running
    localparam logic [REM_W-1:0] INIT_TOP    = 19'h7FFFF;
    localparam logic [REM_W-1:0] INIT_99H    = 19'd359999;
    localparam int unsigned      SECS_HOUR   = 3600;
    localparam int unsigned      SECS_MINUTE = 60;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] caps;
    } timer_event_t;

    typedef struct packed {
        logic [31:0]      seg_ms;
        logic [15:0]      seg_h;
        logic [LED_W-1:0] leds;
        logic [REM_W-1:0] elapsed;
        logic             running;
        clear_t           clear;
    } display_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wen;
    logic [REM_W-1:0] cfg_wdata;

    cdt_cmd_if    cmd_ch ();
    cdt_result_if res_ch ();

    countdown_timer_seven_segment uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    // bench copy of the timer state
    logic [REM_W-1:0]   start_seconds;
    logic [REM_W-1:0]   secs_left;
    logic               counting;
    logic [BLINK_W-1:0] blink_toggles;
    logic [LED_W-1:0]   led_state;

    timer_event_t timer_events[$];     // items still to be sent
    display_t     pending_display[$];  // expected results, oldest first
    display_t     want_display;

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap    = 0;
    int unsigned res_stall   = 0;
    bit          cmd_taken   = 1'b0;
    bit          cmd_steady  = 1'b0;
    bit          res_steady  = 1'b0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] glyph_of(input int unsigned digit);
        case (digit)
            0:       return 8'h3f;
            1:       return 8'h06;
            2:       return 8'h5b;
            3:       return 8'hcf;
            4:       return 8'he6;
            5:       return 8'hed;
            6:       return 8'hfd;
            7:       return 8'h87;
            8:       return 8'hff;
            9:       return 8'hef;
            default: return 8'h3f;
        endcase
    endfunction

    // mostly back-to-back, sometimes a short gap, now and then a long one
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        end
    endtask

    // Apply one accepted item to the bench state and queue the display it
    // should produce.
    task automatic advance_timer(input logic [1:0] kind, input logic [3:0] caps);
        display_t    d;
        clear_t      clear;
        int unsigned secs;
        int unsigned mins;
        int unsigned hours;
        clear = CLEAR_NONE;
        if (kind == KIND_TICK)
        begin
            // ticks do nothing while stopped
            if (counting)
            begin
                if (secs_left == 0)
                begin
                    // at zero: blink, then reload after the last toggle
                    led_state     = ~led_state;
                    blink_toggles = blink_toggles + 1'b1;
                    if (blink_toggles >= 2 * BLINK_TIMES)
                    begin
                        blink_toggles = '0;
                        secs_left     = start_seconds;
                    end
                end
                else
                begin
                    secs_left = secs_left - 1'b1;
                end
            end
        end
        else if (kind == KIND_BUTTON)
        begin
            if (caps >= KEY_RUN)
            begin
                counting = ~counting;
                clear    = CLEAR_RUN;
            end
            else if (caps == KEY_RELOAD)
            begin
                // blink count is deliberately left alone on reload
                secs_left = start_seconds;
                clear     = CLEAR_RELOAD;
            end
            else
            begin
                clear = CLEAR_OTHER;
            end
        end
        // queries and the spare kind only report

        secs  = secs_left % SECS_MINUTE;
        mins  = (secs_left / SECS_MINUTE) % 60;
        hours = (secs_left / SECS_HOUR) % 100;     // 100 h and over wraps on the display
        d.seg_ms  = {glyph_of(mins / 10), glyph_of(mins % 10),
                     glyph_of(secs / 10), glyph_of(secs % 10)};
        d.seg_h   = {glyph_of(hours / 10), glyph_of(hours % 10)};
        d.leds    = led_state;
        d.elapsed = (start_seconds >= secs_left) ? start_seconds - secs_left : '0;
        d.running = counting;
        d.clear   = clear;
        pending_display.push_back(d);
    endtask

    task automatic queue_item(input logic [1:0] kind, input logic [3:0] caps);
        timer_event_t e;
        e.kind = kind;
        e.caps = caps;
        timer_events.push_back(e);
    endtask

    // hold until the sender has nothing left and every result is back
    task automatic wait_drained();
        while (timer_events.size() != 0 || cmd_ch.valid || pending_display.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // register write only with the pipe empty
    task automatic write_start_seconds(input logic [REM_W-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        start_seconds = value;
    endtask

    // ------------------------------------------------------------------------
    // Command driver: changes on the falling edge, holds an item until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        timer_event_t next_event;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_taken)
        begin
            cmd_taken = 1'b0;
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                cmd_ch.valid <= 1'b0;
            end
            else if (timer_events.size() != 0)
            begin
                next_event = timer_events.pop_front();
                cmd_ch.valid   <= 1'b1;
                cmd_ch.kind    <= next_event.kind;
                cmd_ch.buttons <= next_event.caps;
                send_gap = pick_gap(cmd_steady);
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: a random stall may follow each taken result
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (res_stall != 0)
        begin
            res_stall = res_stall - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            res_stall = pick_gap(res_steady);
            if (pending_display.size() == 0)
            begin
                note_mismatch("unexpected result", res_ch.seg_minutes_seconds, 32'd0);
            end
            else
            begin
                want_display = pending_display.pop_front();
                if (res_ch.seg_minutes_seconds !== want_display.seg_ms)
                begin
                    note_mismatch("seg_minutes_seconds", res_ch.seg_minutes_seconds,
                                  want_display.seg_ms);
                end
                if (res_ch.seg_hours !== want_display.seg_h)
                begin
                    note_mismatch("seg_hours", 32'(res_ch.seg_hours),
                                  32'(want_display.seg_h));
                end
                if (res_ch.leds !== want_display.leds)
                begin
                    note_mismatch("leds", 32'(res_ch.leds), 32'(want_display.leds));
                end
                if (res_ch.elapsed_seconds !== want_display.elapsed)
                begin
                    note_mismatch("elapsed_seconds", 32'(res_ch.elapsed_seconds),
                                  32'(want_display.elapsed));
                end
                if (res_ch.running !== want_display.running)
                begin
                    note_mismatch("running", 32'(res_ch.running), 32'(want_display.running));
                end
                if (res_ch.button_clear !== want_display.clear)
                begin
                    note_mismatch("button_clear", 32'(res_ch.button_clear),
                                  32'(want_display.clear));
                end
            end
        end
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            advance_timer(cmd_ch.kind, cmd_ch.buttons);
            cmd_taken = 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      r;
        logic [3:0]       caps;
        logic [1:0]       kind;
        logic [REM_W-1:0] init_value;

        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.kind    = KIND_QUERY;
        cmd_ch.buttons = 4'd0;
        res_ch.ready   = 1'b0;

        start_seconds = INIT_RESET;
        secs_left     = INIT_RESET;
        counting      = 1'b1;
        blink_toggles = '0;
        led_state     = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values, every kind, every class of button capture
        queue_item(KIND_QUERY, 4'd0);
        queue_item(KIND_SPARE, 4'd15);
        queue_item(KIND_TICK, 4'd0);
        queue_item(KIND_BUTTON, 4'd0);
        queue_item(KIND_BUTTON, 4'd6);
        queue_item(KIND_BUTTON, 4'd7);
        queue_item(KIND_BUTTON, KEY_RELOAD);
        queue_item(KIND_BUTTON, KEY_RUN);
        queue_item(KIND_TICK, 4'd0);           // stopped: ignored
        queue_item(KIND_BUTTON, 4'd15);
        queue_item(KIND_TICK, 4'd0);
        wait_drained();

        // Short count: down to zero, full blink, reload, then reload at zero before a blink
        write_start_seconds(19'd2);
        queue_item(KIND_BUTTON, KEY_RELOAD);
        repeat (10) queue_item(KIND_TICK, 4'd0);
        queue_item(KIND_BUTTON, KEY_RELOAD);
        repeat (3) queue_item(KIND_TICK, 4'd0);
        wait_drained();

        // Top of the register: more than 99 hours, wrapped on the display
        write_start_seconds(INIT_TOP);
        queue_item(KIND_BUTTON, KEY_RELOAD);
        queue_item(KIND_TICK, 4'd0);
        wait_drained();

        // Random phases, each opened with a new start value while idle
        sent = 0;
        while (sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0:       init_value = '0;
                1:       init_value = INIT_TOP;
                2:       init_value = INIT_99H;
                3:       init_value = REM_W'($urandom_range(0, 359999));
                default: init_value = REM_W'($urandom_range(1, 12));
            endcase
            write_start_seconds(init_value);
            cmd_steady = ($urandom_range(0, 3) == 0);
            res_steady = ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 1) == 1)
            begin
                queue_item(KIND_BUTTON, KEY_RELOAD);
                sent++;
            end
            phase_len = $urandom_range(15, 60);
            repeat (phase_len)
            begin
                r    = $urandom_range(0, 99);
                caps = 4'($urandom_range(0, 15));
                if (r < 62)
                begin
                    kind = KIND_TICK;
                end
                else if (r < 84)
                begin
                    kind = KIND_BUTTON;
                    r    = $urandom_range(0, 9);
                    if (r < 3)
                    begin
                        caps = KEY_RELOAD;
                    end
                    else if (r < 5)
                    begin
                        caps = 4'($urandom_range(8, 15));
                    end
                end
                else if (r < 95)
                begin
                    kind = KIND_QUERY;
                end
                else
                begin
                    kind = KIND_SPARE;
                end
                queue_item(kind, caps);
            end
            sent += phase_len;
            // sender holds here until the pipe has emptied
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_display.size() != 0)
        begin
            note_mismatch("results missing", pending_display.size(), 32'd0);
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
